@@ rtl/core/mdbu_pkg.sv @@
// Shared types and constants for the multiply/divide/BCD unit.
package mdbu_pkg;

  typedef enum logic [1:0] {
    KIND_MUL16  = 2'd0,
    KIND_MUL32  = 2'd1,
    KIND_DIV32  = 2'd2,
    KIND_BCD    = 2'd3
  } kind_t;

  localparam logic [15:0] BCD_LIMIT = 16'd9999;
  localparam int unsigned DIV_BITS = 32;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
  } req_t;

  typedef struct packed {
    logic [47:0] main_result;
    logic [31:0] remainder;
    logic        divide_by_zero;
  } rsp_t;

  // Per-stage pipeline state: kind, divisor, partial remainder, dividend/quotient shift word, product and BCD digits.
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] divisor;
    logic [32:0] rem;
    logic [31:0] quo;
    logic [47:0] prod;
    logic [15:0] bcd;
  } stg_t;

endpackage

@@ rtl/core/mdbu_if.sv @@
// Valid/ready channel interfaces for request and response beats.
interface mdbu_req_if import mdbu_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mdbu_rsp_if import mdbu_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/multiply_divide_bcd_unit_top.sv @@
// Top level of the multiply/divide/BCD unit.
// Fully pipelined: one beat accepted per cycle unless the output stalls; the
// restoring divider resolves 32/NSTG quotient bits in each of its NSTG
// stages. All kinds travel the same pipe; a stall freezes the whole pipe and
// the output register, and a bubble travels down the pipe with its stage.
module multiply_divide_bcd_unit_top import mdbu_pkg::*; #(
  parameter int unsigned NSTG = 8
) (
  input logic clk,
  input logic rst_n,
  mdbu_req_if.sink   in_req,
  mdbu_rsp_if.source out_rsp
);
  localparam int unsigned STEPS = DIV_BITS / NSTG;

  stg_t        stg_r [NSTG+1];
  stg_t        step_out [NSTG];
  stg_t        front;
  logic [NSTG:0] vld_r;
  logic        adv;
  rsp_t        rsp_nxt;

  assign adv = !vld_r[NSTG] || out_rsp.ready;
  assign in_req.ready = adv;

  mdbu_front u_front (.req(in_req.data), .stg(front));

  for (genvar g = 0; g < NSTG; g++) begin : g_div
    mdbu_div_step #(.STEPS(STEPS)) u_step (.din(stg_r[g]), .dout(step_out[g]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSTG-1:0], in_req.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stg_r[0] <= front;
      for (int i = 0; i < NSTG; i++) stg_r[i+1] <= step_out[i];
    end
  end

  always_comb begin
    rsp_nxt = '0;
    case (kind_t'(stg_r[NSTG].kind))
      KIND_MUL16, KIND_MUL32: rsp_nxt.main_result = stg_r[NSTG].prod;
      KIND_DIV32: begin
        if (stg_r[NSTG].divisor == '0) begin
          rsp_nxt.divide_by_zero = 1'b1;
        end else begin
          rsp_nxt.main_result = 48'(stg_r[NSTG].quo);
          rsp_nxt.remainder   = stg_r[NSTG].rem[31:0];
        end
      end
      KIND_BCD: rsp_nxt.main_result = 48'(stg_r[NSTG].bcd);
      default: rsp_nxt = '0;
    endcase
  end

  assign out_rsp.valid = vld_r[NSTG];
  assign out_rsp.data  = rsp_nxt;
endmodule

@@ rtl/core/mdbu_front.sv @@
// Entry stage: multiplies, BCD conversion and divider set-up.
module mdbu_front import mdbu_pkg::*; (
  input  req_t req,
  output stg_t stg
);
  logic [15:0] v;
  logic [15:0] r;
  logic [3:0]  d3, d2, d1, d0;
  logic [31:0] lo;
  logic [47:0] p1;

  always_comb begin
    v  = (req.operand_a[15:0] > BCD_LIMIT) ? BCD_LIMIT : req.operand_a[15:0];
    d3 = 4'd0;
    for (int i = 1; i < 10; i++) begin
      if (v >= 16'(i * 1000)) d3 = 4'(i);
    end
    r  = v - 16'(d3) * 16'd1000;
    d2 = 4'd0;
    for (int i = 1; i < 10; i++) begin
      if (r >= 16'(i * 100)) d2 = 4'(i);
    end
    r  = r - 16'(d2) * 16'd100;
    d1 = 4'd0;
    for (int i = 1; i < 10; i++) begin
      if (r >= 16'(i * 10)) d1 = 4'(i);
    end
    r  = r - 16'(d1) * 16'd10;
    d0 = r[3:0];
    lo = 32'(req.operand_a[15:0]) * 32'(req.operand_b[15:0]);
    p1 = 48'(req.operand_a) * 48'(req.operand_b[15:0]);
    stg.kind    = req.kind;
    stg.divisor = req.operand_b;
    stg.rem     = '0;
    stg.quo     = req.operand_a;
    stg.prod    = (req.kind == KIND_MUL16) ? 48'(lo) : p1;
    stg.bcd     = {d3, d2, d1, d0};
  end
endmodule

@@ rtl/core/mdbu_div_step.sv @@
// Restoring divider slice: STEPS quotient bits per pipeline stage.
module mdbu_div_step import mdbu_pkg::*; #(
  parameter int unsigned STEPS = 4
) (
  input  stg_t din,
  output stg_t dout
);
  logic [32:0] rem;
  logic [31:0] quo;
  logic [32:0] t;

  always_comb begin
    rem = din.rem;
    quo = din.quo;
    for (int i = 0; i < STEPS; i++) begin
      t = {rem[31:0], quo[31]};
      quo = {quo[30:0], 1'b0};
      if (t >= {1'b0, din.divisor}) begin
        t = t - {1'b0, din.divisor};
        quo[0] = 1'b1;
      end
      rem = t;
    end
    dout     = din;
    dout.rem = rem;
    dout.quo = quo;
  end
endmodule

@@ tb/multiply_divide_bcd_unit_tb.sv @@
// Self-checking testbench for the multiply/divide/BCD unit: directed and random beats.
`timescale 1ns / 1ps

module testbench;
  import mdbu_pkg::*;

  logic clk;
  logic rst_n;
  logic fail_seen;
  rsp_t expected_q[$];

  mdbu_req_if req_ch();
  mdbu_rsp_if rsp_ch();

  multiply_divide_bcd_unit_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (req_ch.sink),
    .out_rsp(rsp_ch.source)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic logic [15:0] bcd_of(logic [15:0] v);
    int unsigned n;
    n = (v > BCD_LIMIT) ? 9999 : v;
    return {4'(n / 1000), 4'((n / 100) % 10), 4'((n / 10) % 10), 4'(n % 10)};
  endfunction

  function automatic rsp_t compute_result(req_t r);
    rsp_t p;
    p = '0;
    case (kind_t'(r.kind))
      KIND_MUL16: p.main_result = 48'(r.operand_a[15:0]) * 48'(r.operand_b[15:0]);
      KIND_MUL32: p.main_result = 48'(r.operand_a) * 48'(r.operand_b[15:0]);
      KIND_DIV32: begin
        if (r.operand_b == 0) begin
          p.divide_by_zero = 1'b1;
        end else begin
          p.main_result = 48'(r.operand_a / r.operand_b);
          p.remainder = r.operand_a % r.operand_b;
        end
      end
      default: p.main_result = 48'(bcd_of(r.operand_a[15:0]));
    endcase
    return p;
  endfunction

  task automatic send_op(kind_t k, logic [31:0] a, logic [31:0] b);
    req_t r;
    int unsigned gap;
    r.kind = k;
    r.operand_a = a;
    r.operand_b = b;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= r;
    do @(posedge clk); while (!req_ch.ready);
    expected_q.push_back(compute_result(r));
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 4))
      0: return 32'($urandom_range(0, 15));
      1: return 32'($urandom_range(0, 65535));
      2: return {$urandom_range(0, 1) ? 16'hffff : 16'h0, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  task automatic test_extremes();
    send_op(KIND_MUL16, 32'hffff_ffff, 32'hffff_ffff);
    send_op(KIND_MUL16, 32'h0, 32'hffff_ffff);
    send_op(KIND_MUL16, 32'hffff_0003, 32'habcd_0005);
    send_op(KIND_MUL32, 32'hffff_ffff, 32'hffff_ffff);
    send_op(KIND_MUL32, 32'hffff_ffff, 32'hffff_0000);
    send_op(KIND_MUL32, 32'h1234_5678, 32'h0001_0001);
  endtask

  task automatic test_divide();
    send_op(KIND_DIV32, 32'hffff_ffff, 32'h0);
    send_op(KIND_DIV32, 32'h0, 32'h0);
    send_op(KIND_DIV32, 32'hffff_ffff, 32'h1);
    send_op(KIND_DIV32, 32'hffff_ffff, 32'hffff_ffff);
    send_op(KIND_DIV32, 32'h7, 32'hffff_ffff);
    send_op(KIND_DIV32, 32'd100, 32'd7);
    send_op(KIND_DIV32, 32'h8000_0000, 32'h3);
  endtask

  task automatic test_bcd();
    send_op(KIND_BCD, 32'd0, 32'hffff_ffff);
    send_op(KIND_BCD, 32'd9999, 32'h0);
    send_op(KIND_BCD, 32'd10000, 32'h0);
    send_op(KIND_BCD, 32'h0000_ffff, 32'h0);
    send_op(KIND_BCD, 32'hffff_1234, 32'h0);
    send_op(KIND_BCD, 32'd1905, 32'h0);
  endtask

  task automatic test_random();
    for (int i = 0; i < 1750; i++) begin
      send_op(kind_t'($urandom_range(0, 3)), rand_word(), rand_word());
    end
  endtask

  initial begin : rsp_drain
    int unsigned idle;
    rsp_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      idle = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 13);
      if (idle != 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (idle) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
    end
  end

  always @(posedge clk) begin
    rsp_t e;
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected beat: main_result %h", rsp_ch.data.main_result);
        fail_seen = 1'b1;
      end else begin
        e = expected_q.pop_front();
        if (rsp_ch.data.main_result !== e.main_result) begin
          $error("main_result: expected %h, actual %h", e.main_result,
                 rsp_ch.data.main_result);
          fail_seen = 1'b1;
        end
        if (rsp_ch.data.remainder !== e.remainder) begin
          $error("remainder: expected %h, actual %h", e.remainder, rsp_ch.data.remainder);
          fail_seen = 1'b1;
        end
        if (rsp_ch.data.divide_by_zero !== e.divide_by_zero) begin
          $error("divide_by_zero: expected %b, actual %b", e.divide_by_zero,
                 rsp_ch.data.divide_by_zero);
          fail_seen = 1'b1;
        end
      end
    end
  end

  initial begin
    fail_seen = 1'b0;
    rst_n = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_divide();
    test_bcd();
    test_random();
    req_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (!fail_seen && expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
